// ===== src/least_runtime_task_scheduler_unit_assert.svh =====
// Assertion macros used by the scheduler top level.
`ifndef LEAST_RUNTIME_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define LEAST_RUNTIME_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LRTS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LRTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lrts_pkg.sv =====
// Shared codes, widths and types of the least-runtime task scheduler.
package lrts_pkg;

    // Transaction kinds on the input stream.
    localparam logic [1:0] KIND_CONFIG   = 2'd0;
    localparam logic [1:0] KIND_PASS     = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;

    // Slot modes as stored in the task table.
    localparam logic [1:0] MODE_INACTIVE = 2'd0;
    localparam logic [1:0] MODE_RUNNING  = 2'd1;
    localparam logic [1:0] MODE_WAITING  = 2'd2;

    // Grant reasons.
    localparam logic [1:0] REASON_NOTIFY = 2'd0;
    localparam logic [1:0] REASON_TIMER  = 2'd1;
    localparam logic [1:0] REASON_LEAST  = 2'd2;

    localparam int NOTIFY_BITS = 8;
    localparam int FIELD_BITS  = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    // Outcome of evaluating one table entry.
    typedef struct packed {
        logic       grant;
        logic [1:0] reason;
        logic       counted;
        logic       take_best;
        logic       wrap;
    } slot_status_t;

endpackage

// ===== src/lrts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/lrts_slot_unit.sv =====
// Shared slot evaluation unit: updates one task table entry per use.
module lrts_slot_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic [1:0]                                    kind,
    input  logic                                          fix_totals,
    input  logic                                          count_ok,
    input  logic                                          best_valid,
    input  logic [TIME_BITS-1:0]                          best_total,
    input  logic [1:0]                                    new_mode,
    input  logic [TIME_BITS-1:0]                          interval,
    input  logic [lrts_pkg::NOTIFY_BITS-1:0]              notify_count,
    input  logic [TIME_BITS-1:0]                          now,
    input  logic [TIME_BITS-1:0]                          elapsed,
    input  logic [2+lrts_pkg::NOTIFY_BITS+4*TIME_BITS-1:0] cur_entry,
    output logic [2+lrts_pkg::NOTIFY_BITS+4*TIME_BITS-1:0] nxt_entry,
    output logic [TIME_BITS-1:0]                          eff_total,
    output lrts_pkg::slot_status_t                        status
);

    import lrts_pkg::*;

    logic [1:0]             cur_mode, nxt_mode;
    logic [NOTIFY_BITS-1:0] cur_notify, nxt_notify;
    logic [TIME_BITS-1:0]   cur_total, nxt_total;
    logic [TIME_BITS-1:0]   cur_last, nxt_last;
    logic [TIME_BITS-1:0]   cur_period, nxt_period;
    logic [TIME_BITS-1:0]   cur_start, nxt_start;
    logic [TIME_BITS:0]     sum;
    logic [TIME_BITS-1:0]   age;

    assign {cur_mode, cur_notify, cur_total, cur_last, cur_period, cur_start} = cur_entry;
    assign nxt_entry = {nxt_mode, nxt_notify, nxt_total, nxt_last, nxt_period, nxt_start};

    // A pending wrap makes every total fall back to its last runtime.
    assign eff_total = fix_totals ? cur_last : cur_total;
    assign sum       = {1'b0, cur_total} + {1'b0, elapsed};
    assign age       = now - cur_start;

    always_comb
    begin
        nxt_mode   = cur_mode;
        nxt_notify = cur_notify;
        nxt_total  = cur_total;
        nxt_last   = cur_last;
        nxt_period = cur_period;
        nxt_start  = cur_start;
        status     = '0;
        case (kind)
            KIND_CONFIG:
            begin
                if (new_mode == MODE_RUNNING || new_mode == MODE_WAITING)
                begin
                    nxt_mode = new_mode;
                end
                else
                begin
                    nxt_mode = MODE_INACTIVE;
                end
                nxt_period = interval;
                nxt_notify = notify_count;
                nxt_start  = now;
            end
            KIND_COMPLETE:
            begin
                nxt_last    = elapsed;
                nxt_total   = sum[TIME_BITS-1:0];
                status.wrap = sum[TIME_BITS];
            end
            KIND_PASS:
            begin
                nxt_total = eff_total;
                if (cur_mode == MODE_WAITING && count_ok)
                begin
                    status.counted = 1'b1;
                    if (cur_notify != '0)
                    begin
                        status.grant  = 1'b1;
                        status.reason = REASON_NOTIFY;
                        nxt_notify    = '0;
                    end
                    else if (cur_period != '0 && age > cur_period)
                    begin
                        status.grant  = 1'b1;
                        status.reason = REASON_TIMER;
                        nxt_start     = now;
                    end
                end
                if (cur_mode == MODE_RUNNING && (!best_valid || eff_total < best_total))
                begin
                    status.take_best = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== src/least_runtime_task_scheduler_unit.sv =====
// Top level of the least-runtime cooperative task scheduler.
//
// Input stream (s_axis): one transaction is a configure, a scheduling pass or a
// run completion, selected by s_axis_tuser. Output stream (m_axis): result
// transactions; every input transaction gives one or more results and the
// final one carries m_axis_tlast. A pass gives one result per grant, waiting
// slots in slot order first and the least-runtime running slot last, or a
// single non-grant result when nothing is granted.
// The task table sits in a RAM that is swept by one shared slot evaluation
// unit, one entry per cycle while the sweep is not held, with a
// read-modify-write pipeline. A configure or completion sweeps only its own
// entry, a pass sweeps every entry and an undefined kind sweeps none; the
// final result is loaded once the sweep has ended, and for a pass once the
// least-runtime grant has been placed. A new transaction is not taken before
// then: the input is ready again the cycle after the final result is loaded,
// while that result may still wait in the output register.
// When the receiver stalls, the sweep holds as soon as a further grant has
// no place to go; nothing is dropped. At reset every table entry reads as
// inactive with zero times through per-entry fill flags, so no clearing pass
// is needed and the block is ready as soon as reset ends.
`include "least_runtime_task_scheduler_unit_assert.svh"

module least_runtime_task_scheduler_unit #(
    parameter int TASK_SLOTS    = 16,
    parameter int WAITING_LIMIT = 16,
    parameter int TIME_BITS     = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot[3:0], task_mode[5:4], timer_interval[37:6], notify_count[45:38],
    // now[77:46], elapsed[109:78], zero fill[111:110]
    input  logic [111:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // grant_slot[3:0], grant_reason[5:4], overflow_pending[6], zero fill[7]
    output logic [7:0]   m_axis_tdata,
    // grant_valid[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    import lrts_pkg::*;

    localparam int SLOT_BITS = $clog2(TASK_SLOTS);
    localparam int CNT_BITS  = $clog2(TASK_SLOTS + 1);
    localparam int SEEN_BITS = $clog2(WAITING_LIMIT + 1);
    localparam int ENTRY_W   = 2 + NOTIFY_BITS + 4 * TIME_BITS;

    // Input fields.
    logic [1:0]             in_kind;
    logic [3:0]             in_slot;
    logic [1:0]             in_mode;
    logic [FIELD_BITS-1:0]  in_interval;
    logic [NOTIFY_BITS-1:0] in_notify;
    logic [FIELD_BITS-1:0]  in_now;
    logic [FIELD_BITS-1:0]  in_elapsed;

    assign in_kind     = s_axis_tuser;
    assign in_slot     = s_axis_tdata[3:0];
    assign in_mode     = s_axis_tdata[5:4];
    assign in_interval = s_axis_tdata[37:6];
    assign in_notify   = s_axis_tdata[45:38];
    assign in_now      = s_axis_tdata[77:46];
    assign in_elapsed  = s_axis_tdata[109:78];

    state_t state_reg, state_next;

    // Latched transaction.
    logic [1:0]             kind_reg;
    logic [1:0]             mode_reg;
    logic [TIME_BITS-1:0]   interval_reg;
    logic [NOTIFY_BITS-1:0] notify_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   elapsed_reg;
    logic                   fix_reg;

    // Sweep pipeline.
    logic [CNT_BITS-1:0]    rd_idx_reg;
    logic [CNT_BITS-1:0]    scan_end_reg;
    logic                   ev_valid_reg;
    logic [SLOT_BITS-1:0]   ev_idx_reg;
    logic                   rd_filled_reg;
    logic [TASK_SLOTS-1:0]  filled_reg;
    logic [SEEN_BITS-1:0]   seen_reg;

    // Least-runtime candidate and the grant held back for the tlast decision.
    logic                   best_valid_reg;
    logic [SLOT_BITS-1:0]   best_idx_reg;
    logic [TIME_BITS-1:0]   best_total_reg;
    logic                   held_valid_reg;
    logic [SLOT_BITS-1:0]   held_slot_reg;
    logic [1:0]             held_reason_reg;
    logic                   wrapped_reg;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_grant_reg;
    logic [3:0]             out_slot_reg;
    logic [1:0]             out_reason_reg;
    logic                   out_last_reg;
    logic                   out_ovf_reg;

    logic                   accept;
    logic                   in_range;
    logic                   scan_item;
    logic                   out_free;
    logic                   stall;
    logic                   advance;
    logic                   issue;
    logic                   commit;
    logic                   count_ok;
    logic [ENTRY_W-1:0]     ram_q;
    logic [ENTRY_W-1:0]     cur_entry;
    logic [ENTRY_W-1:0]     nxt_entry;
    logic [TIME_BITS-1:0]   eff_total;
    slot_status_t           status;

    logic                   out_load;
    logic                   out_grant_next;
    logic [3:0]             out_slot_next;
    logic [1:0]             out_reason_next;
    logic                   out_last_next;
    logic                   held_load;
    logic [SLOT_BITS-1:0]   held_slot_next;
    logic [1:0]             held_reason_next;
    logic                   held_clear;
    logic                   best_clear;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_range      = 32'(in_slot) < 32'(TASK_SLOTS);
    assign scan_item     = (in_kind == KIND_PASS) ||
                           ((in_kind == KIND_CONFIG || in_kind == KIND_COMPLETE) && in_range);

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign count_ok  = seen_reg < SEEN_BITS'(WAITING_LIMIT);
    assign cur_entry = rd_filled_reg ? ram_q : '0;

    // A second grant while one is held needs the output register.
    assign stall   = ev_valid_reg && status.grant && held_valid_reg && !out_free;
    assign advance = (state_reg == ST_SCAN) && !stall;
    assign issue   = advance && (rd_idx_reg != scan_end_reg);
    assign commit  = advance && ev_valid_reg;

    lrts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (ev_idx_reg),
        .wr_data (nxt_entry),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[SLOT_BITS-1:0]),
        .rd_data (ram_q)
    );

    lrts_slot_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_slot_unit (
        .kind         (kind_reg),
        .fix_totals   (fix_reg),
        .count_ok     (count_ok),
        .best_valid   (best_valid_reg),
        .best_total   (best_total_reg),
        .new_mode     (mode_reg),
        .interval     (interval_reg),
        .notify_count (notify_reg),
        .now          (now_reg),
        .elapsed      (elapsed_reg),
        .cur_entry    (cur_entry),
        .nxt_entry    (nxt_entry),
        .eff_total    (eff_total),
        .status       (status)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = scan_item ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (!ev_valid_reg && rd_idx_reg == scan_end_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!best_valid_reg && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result sequencing: a grant is held until the next one shows whether it
    // is the final result of the transaction.
    always_comb
    begin
        out_load         = 1'b0;
        out_grant_next   = held_valid_reg;
        out_slot_next    = 4'(held_slot_reg);
        out_reason_next  = held_reason_reg;
        out_last_next    = 1'b0;
        held_load        = 1'b0;
        held_slot_next   = ev_idx_reg;
        held_reason_next = status.reason;
        held_clear       = 1'b0;
        best_clear       = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                if (commit && status.grant)
                begin
                    out_load  = held_valid_reg;
                    held_load = 1'b1;
                end
            end
            ST_FIN:
            begin
                held_slot_next   = best_idx_reg;
                held_reason_next = REASON_LEAST;
                if (best_valid_reg)
                begin
                    if (!held_valid_reg)
                    begin
                        held_load  = 1'b1;
                        best_clear = 1'b1;
                    end
                    else if (out_free)
                    begin
                        out_load   = 1'b1;
                        held_load  = 1'b1;
                        best_clear = 1'b1;
                    end
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    held_clear    = 1'b1;
                    if (!held_valid_reg)
                    begin
                        out_slot_next   = '0;
                        out_reason_next = REASON_NOTIFY;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fix_reg        <= 1'b0;
            rd_idx_reg     <= '0;
            scan_end_reg   <= '0;
            ev_valid_reg   <= 1'b0;
            rd_filled_reg  <= 1'b0;
            filled_reg     <= '0;
            seen_reg       <= '0;
            best_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            wrapped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                fix_reg        <= (in_kind == KIND_PASS) && wrapped_reg;
                seen_reg       <= '0;
                best_valid_reg <= 1'b0;
                held_valid_reg <= 1'b0;
                if (in_kind == KIND_PASS)
                begin
                    wrapped_reg  <= 1'b0;
                    rd_idx_reg   <= '0;
                    scan_end_reg <= CNT_BITS'(TASK_SLOTS);
                end
                else
                begin
                    rd_idx_reg   <= CNT_BITS'(in_slot);
                    scan_end_reg <= CNT_BITS'(in_slot) + CNT_BITS'(1);
                end
            end

            if (advance)
            begin
                ev_valid_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg    <= rd_idx_reg + CNT_BITS'(1);
                    rd_filled_reg <= filled_reg[rd_idx_reg[SLOT_BITS-1:0]];
                end
            end

            if (commit)
            begin
                filled_reg[ev_idx_reg] <= 1'b1;
                if (status.counted)
                begin
                    seen_reg <= seen_reg + SEEN_BITS'(1);
                end
                if (status.take_best)
                begin
                    best_valid_reg <= 1'b1;
                end
                if (status.wrap)
                begin
                    wrapped_reg <= 1'b1;
                end
            end

            if (best_clear)
            begin
                best_valid_reg <= 1'b0;
            end

            if (held_load)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (held_clear)
            begin
                held_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= in_kind;
            mode_reg     <= in_mode;
            interval_reg <= TIME_BITS'(in_interval);
            notify_reg   <= in_notify;
            now_reg      <= TIME_BITS'(in_now);
            elapsed_reg  <= TIME_BITS'(in_elapsed);
        end
        if (advance)
        begin
            ev_idx_reg <= rd_idx_reg[SLOT_BITS-1:0];
        end
        if (commit && status.take_best)
        begin
            best_idx_reg   <= ev_idx_reg;
            best_total_reg <= eff_total;
        end
        if (held_load)
        begin
            held_slot_reg   <= held_slot_next;
            held_reason_reg <= held_reason_next;
        end
        if (out_load)
        begin
            out_grant_reg  <= out_grant_next;
            out_slot_reg   <= out_slot_next;
            out_reason_reg <= out_reason_next;
            out_last_reg   <= out_last_next;
            out_ovf_reg    <= wrapped_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_ovf_reg, out_reason_reg, out_slot_reg};
    assign m_axis_tuser  = out_grant_reg;
    assign m_axis_tlast  = out_last_reg;

    `LRTS_ASSERT_IMPLY(a_idle_clean, s_axis_tready,
        !ev_valid_reg && !held_valid_reg && !best_valid_reg,
        "work left over when taking a new transaction")
    `LRTS_ASSERT_IMPLY(a_stall_only_when_blocked, (state_reg == ST_SCAN) && stall,
        m_axis_tvalid && !m_axis_tready, "sweep held while output was free")
    `LRTS_ASSERT_NEXT(a_last_returns_idle, out_load && out_last_next,
        state_reg == ST_IDLE, "final result did not end the transaction")
    `LRTS_ASSERT_NEXT(a_pass_clears_wrap, accept && (in_kind == KIND_PASS),
        !wrapped_reg, "pass left the runtime wrap flag set")
    `LRTS_ASSERT_IMPLY(a_scan_in_bounds, state_reg == ST_SCAN,
        rd_idx_reg <= scan_end_reg, "sweep ran past its end")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the least-runtime task scheduler unit.
`timescale 1ns / 1ps

// The testbench keeps its own copy of the task table and predicts every
// grant that the unit should issue.
//
// The run has two parts:
// - A directed table covers reset, the undefined kind and mode, all-ones
//   fields, a runtime wrap, a timer that wraps around, ties on the
//   least-runtime pick, and a slot whose total is the largest time value.
// - A random part follows, in three stretches. In the first the receiver is
//   idle more often than the sender, in the second it is the other way
//   round, and in the third neither side is idle.
//
// Every result transaction is compared with the oldest expected grant.
module testbench;

    import lrts_pkg::*;

    localparam int          SLOT_COUNT    = 16;
    localparam int          WAIT_LIMIT    = 16;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int          REPORT_LIMIT  = 10;
    // Codes that the package leaves undefined; the unit must tolerate them.
    localparam logic [1:0]  KIND_UNDEFINED = 2'd3;
    localparam logic [1:0]  MODE_UNDEFINED = 2'd3;

    // One input transaction, field by field.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [1:0]  mode;
        logic [31:0] interval;
        logic [7:0]  notify;
        logic [31:0] stamp;
        logic [31:0] elapsed;
    } sched_item_t;

    // One result transaction, field by field.
    typedef struct packed {
        logic       valid;
        logic [3:0] slot;
        logic [1:0] reason;
        logic       last;
        logic       overflow;
    } grant_t;

    // A row of the directed table; typed rows carry their expected result.
    typedef struct {
        sched_item_t item;
        bit          typed;
        grant_t      want;
    } directed_row_t;

    localparam grant_t NON_GRANT   = '{1'b0, 4'd0, REASON_NOTIFY, 1'b1, 1'b0};
    localparam grant_t WRAP_NOTICE = '{1'b0, 4'd0, REASON_NOTIFY, 1'b1, 1'b1};

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // slot, task_mode, timer_interval, notify_count, now, elapsed, zero fill
    logic [111:0] s_axis_tdata = '0;
    // kind
    logic [1:0]   s_axis_tuser = KIND_CONFIG;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // grant_slot, grant_reason, overflow_pending, zero fill
    logic [7:0]   m_axis_tdata;
    // grant_valid
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    // Predicted copy of the task table.
    logic [1:0]   tbl_mode    [SLOT_COUNT];
    logic [31:0]  tbl_total   [SLOT_COUNT];
    logic [31:0]  tbl_last    [SLOT_COUNT];
    logic [7:0]   tbl_notify  [SLOT_COUNT];
    logic [31:0]  tbl_period  [SLOT_COUNT];
    logic [31:0]  tbl_start   [SLOT_COUNT];
    logic         tbl_wrapped;

    grant_t        expected_grants[$];
    directed_row_t directed_rows[$];
    int            mismatches = 0;
    int            cycle_count = 0;
    int            sender_idle_pct = 27;
    int            receiver_idle_pct = 59;
    logic [31:0]   clock_stamp = '0;

    least_runtime_task_scheduler_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Applies one accepted transaction to the table copy and queues its grants.
    // A typed row queues its hand-written result in place of the computed one,
    // but the table copy is still updated.
    task automatic predict_grants(input sched_item_t it, input bit typed,
                                  input grant_t want);
        grant_t      found[$];
        grant_t      g;
        int          seen;
        int          best;
        logic [31:0] prev;
        logic [31:0] age;
        seen = 0;
        best = -1;
        if (it.kind == KIND_CONFIG) begin
            tbl_mode[it.slot]   = (it.mode == MODE_UNDEFINED) ? MODE_INACTIVE : it.mode;
            tbl_period[it.slot] = it.interval;
            tbl_notify[it.slot] = it.notify;
            tbl_start[it.slot]  = it.stamp;
        end else if (it.kind == KIND_COMPLETE) begin
            prev                = tbl_total[it.slot];
            tbl_last[it.slot]   = it.elapsed;
            tbl_total[it.slot]  = prev + it.elapsed;
            if (tbl_total[it.slot] < prev) begin
                tbl_wrapped = 1'b1;
            end
        end else if (it.kind == KIND_PASS) begin
            // A pending wrap is undone before any slot is looked at.
            if (tbl_wrapped) begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    tbl_total[i] = tbl_last[i];
                end
                tbl_wrapped = 1'b0;
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (tbl_mode[i] == MODE_WAITING) begin
                    if (seen >= WAIT_LIMIT) begin
                        break;
                    end
                    seen++;
                    if (tbl_notify[i] != 0) begin
                        found.push_back('{1'b1, i[3:0], REASON_NOTIFY, 1'b0, tbl_wrapped});
                        tbl_notify[i] = '0;
                    end else if (tbl_period[i] != 0) begin
                        // The age is taken modulo the time width, so a stamp
                        // that wrapped around still ages the timer.
                        age = it.stamp - tbl_start[i];
                        if (age > tbl_period[i]) begin
                            found.push_back('{1'b1, i[3:0], REASON_TIMER, 1'b0,
                                              tbl_wrapped});
                            tbl_start[i] = it.stamp;
                        end
                    end
                end
            end
            // Least total wins; a strict compare leaves ties to the lowest slot.
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (tbl_mode[i] == MODE_RUNNING &&
                    (best < 0 || tbl_total[i] < tbl_total[best])) begin
                    best = i;
                end
            end
            if (best >= 0) begin
                found.push_back('{1'b1, best[3:0], REASON_LEAST, 1'b0, tbl_wrapped});
            end
        end
        if (found.size() == 0) begin
            found.push_back('{1'b0, 4'd0, REASON_NOTIFY, 1'b1, tbl_wrapped});
        end else begin
            g = found[found.size() - 1];
            g.last = 1'b1;
            found[found.size() - 1] = g;
        end
        if (typed) begin
            expected_grants.push_back(want);
        end else begin
            foreach (found[k]) begin
                expected_grants.push_back(found[k]);
            end
        end
    endtask

    // Offers one transaction and predicts its grants once it is taken.
    // Valid is only lowered while the sender idles, so back-to-back
    // transactions keep it high without a glitch in the same time step.
    task automatic send_item(input sched_item_t it, input bit typed, input grant_t want);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {2'b00, it.elapsed, it.stamp, it.notify, it.interval,
                          it.mode, it.slot};
        do begin
            @(posedge clk);
        end while (!s_axis_tready);
        predict_grants(it, typed, want);
    endtask

    function automatic sched_item_t make_item(logic [1:0] kind, logic [3:0] slot,
                                              logic [1:0] mode, logic [31:0] interval,
                                              logic [7:0] notify, logic [31:0] stamp,
                                              logic [31:0] elapsed);
        sched_item_t it;
        it = '{kind, slot, mode, interval, notify, stamp, elapsed};
        return it;
    endfunction

    // Random transaction. The time stamp mostly creeps forward so that timers
    // expire now and then, and sometimes jumps anywhere in the 32-bit range.
    // Elapsed times are mostly small, with some near the top to force wraps.
    function automatic sched_item_t random_item();
        sched_item_t it;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            it.kind = KIND_UNDEFINED;
        end else if (pick < 40) begin
            it.kind = KIND_CONFIG;
        end else if (pick < 68) begin
            it.kind = KIND_PASS;
        end else begin
            it.kind = KIND_COMPLETE;
        end
        it.slot = 4'($urandom_range(SLOT_COUNT - 1));
        pick = $urandom_range(99);
        if (pick < 40) begin
            it.mode = MODE_WAITING;
        end else if (pick < 80) begin
            it.mode = MODE_RUNNING;
        end else if (pick < 94) begin
            it.mode = MODE_INACTIVE;
        end else begin
            it.mode = MODE_UNDEFINED;
        end
        pick = $urandom_range(99);
        if (pick < 20) begin
            it.interval = '0;
        end else if (pick < 85) begin
            it.interval = 32'($urandom_range(40, 1));
        end else begin
            it.interval = $urandom;
        end
        it.notify = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255));
        if ($urandom_range(99) < 5) begin
            clock_stamp = $urandom;
        end else begin
            clock_stamp = clock_stamp + 32'($urandom_range(15));
        end
        it.stamp = clock_stamp;
        pick = $urandom_range(99);
        if (pick < 80) begin
            it.elapsed = 32'($urandom_range(1000));
        end else if (pick < 90) begin
            it.elapsed = 32'hFFFF_FFFF - 32'($urandom_range(500));
        end else begin
            it.elapsed = $urandom;
        end
        return it;
    endfunction

    // Random stretch. Now and then a full table is set up and then passed, which
    // produces the longest runs of grants with random content.
    task automatic run_random(input int sender_pct, input int receiver_pct,
                              input int item_count);
        sched_item_t it;
        int          sent;
        sent = 0;
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        while (sent < item_count) begin
            if ($urandom_range(99) < 4) begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    it = random_item();
                    it.kind   = KIND_CONFIG;
                    it.slot   = 4'(i);
                    it.mode   = ($urandom_range(3) == 0) ? MODE_RUNNING : MODE_WAITING;
                    it.notify = 8'($urandom_range(255, 1));
                    send_item(it, 1'b0, NON_GRANT);
                end
                it = random_item();
                it.kind = KIND_PASS;
                send_item(it, 1'b0, NON_GRANT);
                sent += SLOT_COUNT + 1;
            end else begin
                send_item(random_item(), 1'b0, NON_GRANT);
                sent++;
            end
        end
    endtask

    // Receiver side: random back-pressure and the result check.
    always @(posedge clk) begin
        grant_t got;
        grant_t want;
        if (rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[5:4],
                        m_axis_tlast, m_axis_tdata[6]};
                if (expected_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected result: valid %0d slot %0d reason %0d last %0d ovf %0d",
                                 got.valid, got.slot, got.reason, got.last, got.overflow);
                    end
                end else begin
                    want = expected_grants.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("result differs: expected valid %0d slot %0d reason %0d last %0d ovf %0d, got valid %0d slot %0d reason %0d last %0d ovf %0d",
                                     want.valid, want.slot, want.reason, want.last,
                                     want.overflow, got.valid, got.slot, got.reason,
                                     got.last, got.overflow);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("least_runtime_task_scheduler_unit: mismatch");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_mode[i]   = MODE_INACTIVE;
            tbl_total[i]  = '0;
            tbl_last[i]   = '0;
            tbl_notify[i] = '0;
            tbl_period[i] = '0;
            tbl_start[i]  = '0;
        end
        tbl_wrapped = 1'b0;

        // Directed rows. Rows with an obvious outcome carry it; the passes
        // that grant slots are left to the predictor.
        // Nothing is configured right after reset, so a pass grants nothing.
        directed_rows.push_back('{make_item(KIND_PASS, 4'd0, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd0, 32'd0), 1'b1, NON_GRANT});
        // The undefined kind with every field at all ones is ignored.
        directed_rows.push_back('{make_item(KIND_UNDEFINED, 4'hF, MODE_UNDEFINED,
                                            32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF), 1'b1, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'd0, MODE_RUNNING, 32'd0, 8'd0,
                                            32'd0, 32'd0), 1'b1, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'hF, MODE_WAITING, 32'hFFFF_FFFF,
                                            8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                                  1'b1, NON_GRANT});
        // The undefined mode must be stored as inactive.
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'd5, MODE_UNDEFINED, 32'd7, 8'd3,
                                            32'd0, 32'd0), 1'b1, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'd3, MODE_WAITING, 32'd10, 8'd0,
                                            32'd100, 32'd0), 1'b1, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'd1, MODE_RUNNING, 32'd0, 8'd0,
                                            32'd100, 32'd0), 1'b1, NON_GRANT});
        // A waiting slot with its timer off and no notifications never runs.
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'd4, MODE_WAITING, 32'd0, 8'd0,
                                            32'd100, 32'd0), 1'b1, NON_GRANT});
        // This completion reaches the top without wrapping; the next one wraps.
        directed_rows.push_back('{make_item(KIND_COMPLETE, 4'd0, MODE_INACTIVE, 32'd0,
                                            8'd0, 32'd0, 32'hFFFF_FFFF), 1'b1, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_COMPLETE, 4'd0, MODE_INACTIVE, 32'd0,
                                            8'd0, 32'd0, 32'd2), 1'b1, WRAP_NOTICE});
        // The pass clears the wrap, then grants a notification and the least total.
        directed_rows.push_back('{make_item(KIND_PASS, 4'd0, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd105, 32'd0), 1'b0, NON_GRANT});
        // The timer of slot 3 has just expired.
        directed_rows.push_back('{make_item(KIND_PASS, 4'd0, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd111, 32'd0), 1'b0, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_PASS, 4'd0, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd111, 32'd0), 1'b0, NON_GRANT});
        // Equal totals on slots 0 and 1: the lower slot wins.
        directed_rows.push_back('{make_item(KIND_COMPLETE, 4'd1, MODE_INACTIVE, 32'd0,
                                            8'd0, 32'd0, 32'd2), 1'b1, NON_GRANT});
        // An age equal to the period is not yet expired; one more tick is.
        directed_rows.push_back('{make_item(KIND_PASS, 4'd0, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd121, 32'd0), 1'b0, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_PASS, 4'd0, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd122, 32'd0), 1'b0, NON_GRANT});
        // Leave only slot 7 running, with a total at the largest time value.
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'd0, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd122, 32'd0), 1'b1, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'd1, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd122, 32'd0), 1'b1, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_CONFIG, 4'd7, MODE_RUNNING, 32'd0, 8'd0,
                                            32'd122, 32'd0), 1'b1, NON_GRANT});
        directed_rows.push_back('{make_item(KIND_COMPLETE, 4'd7, MODE_INACTIVE, 32'd0,
                                            8'd0, 32'd0, 32'hFFFF_FFFF), 1'b1, NON_GRANT});
        // The stamp wraps to zero: the age of slot 3 wraps around and expires.
        directed_rows.push_back('{make_item(KIND_PASS, 4'd0, MODE_INACTIVE, 32'd0, 8'd0,
                                            32'd0, 32'd0), 1'b0, NON_GRANT});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end

        run_random(27, 59, 155);
        run_random(59, 27, 155);
        run_random(0, 0, 160);
        s_axis_tvalid <= 1'b0;

        while (expected_grants.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_grants.size() == 0) begin
            $display("least_runtime_task_scheduler_unit: match");
        end else begin
            $display("least_runtime_task_scheduler_unit: mismatch");
        end
        $finish;
    end

endmodule
